FILE: hdl/ifd_pkg.sv
// Shared types and constants for the IMU frame deframer.
package ifd_pkg;

  localparam int FRAME_LEN  = 42;
  localparam int HOLD_LEN   = FRAME_LEN - 1;
  localparam int WORD_COUNT = 10;
  localparam int FILL_W     = 6;

  localparam logic [FILL_W-1:0] HOLD_COUNT = FILL_W'(HOLD_LEN);

  localparam logic [7:0] REG_SYNC_HEADER  = 8'd0;
  localparam logic [7:0] REG_SYNC_TRAILER = 8'd1;

  localparam logic [7:0] SYNC_HEADER_RESET  = 8'h80;
  localparam logic [7:0] SYNC_TRAILER_RESET = 8'h40;

  typedef logic [HOLD_LEN-1:0][7:0] window_t;
  typedef logic [WORD_COUNT-1:0][31:0] words_t;

  // Handshake summary from the window to the result register.
  typedef struct packed {
    logic take;
    logic hit;
  } win_ctrl_t;

endpackage

FILE: hdl/imu_frame_deframer.sv
// Top level of the IMU frame deframer: config registers, window and result.
//
//   channel  direction  handshake              payload
//   in       receive    in_valid / in_stall    rx_byte
//   out      send       out_valid / out_stall  accel_xyz, rate_xyz, quat_xyzw
//   cfg      receive    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken every cycle; a frame appears on the output the cycle after
// its trailer byte is taken. Reset empties the window and restores the sync
// values. While a finished frame waits, bytes that do not complete a frame are
// still taken; only a byte that would complete the next frame is stalled.
// Configuration writes are always ready and take effect on the next cycle.
module imu_frame_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] accel_x,
  output logic signed [31:0] accel_y,
  output logic signed [31:0] accel_z,
  output logic signed [31:0] rate_x,
  output logic signed [31:0] rate_y,
  output logic signed [31:0] rate_z,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic signed [31:0] quat_w,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  logic [7:0]          sync_header;
  logic [7:0]          sync_trailer;
  logic                hit;
  ifd_pkg::words_t     words;
  ifd_pkg::words_t     out_words;
  ifd_pkg::win_ctrl_t  ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_header  <= ifd_pkg::SYNC_HEADER_RESET;
      sync_trailer <= ifd_pkg::SYNC_TRAILER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ifd_pkg::REG_SYNC_HEADER:  sync_header  <= cfg_data;
        ifd_pkg::REG_SYNC_TRAILER: sync_trailer <= cfg_data;
        default: ;
      endcase
    end
  end

  // Only a completing byte has to wait for the result register.
  assign in_stall  = hit && out_valid && out_stall;
  assign ctrl.take = in_valid && !in_stall;
  assign ctrl.hit  = hit;

  ifd_window u_window (
    .clk          (clk),
    .rst          (rst),
    .take         (ctrl.take),
    .rx_byte      (rx_byte),
    .sync_header  (sync_header),
    .sync_trailer (sync_trailer),
    .hit          (hit),
    .words        (words)
  );

  ifd_result u_result (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .words     (words),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_words (out_words)
  );

  assign accel_x = $signed(out_words[0]);
  assign accel_y = $signed(out_words[1]);
  assign accel_z = $signed(out_words[2]);
  assign rate_x  = $signed(out_words[3]);
  assign rate_y  = $signed(out_words[4]);
  assign rate_z  = $signed(out_words[5]);
  assign quat_x  = $signed(out_words[6]);
  assign quat_y  = $signed(out_words[7]);
  assign quat_z  = $signed(out_words[8]);
  assign quat_w  = $signed(out_words[9]);

endmodule

FILE: hdl/ifd_window.sv
// Byte window shift register, fill count and frame sync match.
module ifd_window (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          sync_header,
  input  logic [7:0]          sync_trailer,
  output logic                hit,
  output ifd_pkg::words_t     words
);

  ifd_pkg::window_t                 window;
  logic [ifd_pkg::FILL_W-1:0]       fill_count;
  logic [ifd_pkg::FILL_W-1:0]       fill_count_next;

  // The window holds the 41 bytes before the incoming one, newest at the top.
  // With the incoming byte appended it forms the full 42-byte frame.
  assign hit = (fill_count == ifd_pkg::HOLD_COUNT) &&
               (window[0] == sync_header) && (rx_byte == sync_trailer);

  always_comb begin
    for (int k = 0; k < ifd_pkg::WORD_COUNT; k++) begin
      words[k] = {window[4*k+4], window[4*k+3], window[4*k+2], window[4*k+1]};
    end
  end

  always_comb begin
    fill_count_next = fill_count;
    if (take) begin
      if (hit) begin
        fill_count_next = '0;
      end else if (fill_count != ifd_pkg::HOLD_COUNT) begin
        fill_count_next = fill_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  // Stale bytes below the fill level are never looked at, so the shift runs freely.
  always_ff @(posedge clk) begin
    if (take) begin
      window <= {rx_byte, window[ifd_pkg::HOLD_LEN-1:1]};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= ifd_pkg::HOLD_COUNT)
    else $error("fill count above window depth");

  a_hit_clears: assert property (@(posedge clk) disable iff (rst)
    take && hit |=> fill_count == '0)
    else $error("window not emptied after a frame");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    take && !hit && fill_count != ifd_pkg::HOLD_COUNT |=>
      fill_count == $past(fill_count) + 1'b1)
    else $error("fill count did not advance");

endmodule

FILE: hdl/ifd_result.sv
// Result register holding one decoded frame until it is taken.
module ifd_result (
  input  logic                   clk,
  input  logic                   rst,
  input  ifd_pkg::win_ctrl_t     ctrl,
  input  ifd_pkg::words_t        words,
  input  logic                   out_stall,
  output logic                   out_valid,
  output ifd_pkg::words_t        out_words
);

  logic load;

  assign load = ctrl.take && ctrl.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_words <= words;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !(out_valid && out_stall))
    else $error("pending frame overwritten");

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_words))
    else $error("pending frame lost while stalled");

endmodule
